// File: sv/plll_pkg.sv
// Shared types, codes and constants of the piecewise linear latency lookup.
package plll_pkg;

    localparam int MAX_POINTS_DEF = 32;
    localparam int NUM_CURVES_DEF = 6;

    localparam int VAL_W  = 40;
    localparam int LAT_W  = 48;
    localparam int PROD_W = 89;
    localparam int QUO_W  = 51;
    localparam int SUM_W  = 53;

    localparam logic [QUO_W-1:0] TERM_CAP = QUO_W'(1) << 50;
    localparam logic signed [SUM_W-1:0] LAT_MAX = 53'sd140737488355327;
    localparam logic signed [SUM_W-1:0] LAT_MIN = -53'sd140737488355328;

    typedef enum logic [1:0] {
        OP_WR_SIZE = 2'd0,
        OP_WR_LAT  = 2'd1,
        OP_QUERY   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ZERO   = 2'd1,
        ST_NONPOS = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_POINT_COUNT   = 2'd0,
        CFG_MEMORY_SLOPE  = 2'd1,
        CFG_STORAGE_SLOPE = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        M_ONE = 2'd0,
        M_EXT = 2'd1,
        M_INT = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        B_IDLE     = 4'd0,
        B_RD_LAST  = 4'd1,
        B_GOT_LAST = 4'd2,
        B_RD_S     = 4'd3,
        B_GOT_S    = 4'd4,
        B_RD_LA    = 4'd5,
        B_GOT_LA   = 4'd6,
        B_RD_LB    = 4'd7,
        B_GOT_LB   = 4'd8,
        B_MUL      = 4'd9,
        B_SHIFT    = 4'd10,
        B_DIV      = 4'd11,
        B_FIN      = 4'd12,
        B_OUT      = 4'd13
    } t_bstate;

    typedef struct packed {
        t_op               operation;
        logic [2:0]        curve;
        logic [4:0]        index;
        logic [VAL_W-1:0]  point_value;
        logic [VAL_W-1:0]  query_size;
    } t_in;

    typedef struct packed {
        logic signed [LAT_W-1:0] latency;
        t_status                 status;
    } t_out;

    typedef struct packed {
        t_op               op;
        logic              bad;
        logic              zero;
        logic [2:0]        curve;
        logic [4:0]        index;
        logic [VAL_W-1:0]  value;
        logic [VAL_W-1:0]  size;
    } t_qent;

    typedef struct packed {
        logic [5:0]              point_count;
        logic signed [LAT_W-1:0] memory_slope;
        logic signed [LAT_W-1:0] storage_slope;
    } t_cfg;

endpackage

// File: sv/plll_ram.sv
// Generic single write port RAM with a registered read port.
module plll_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/plll_front.sv
// Front end: accepts input beats, classifies them and queues them for the back end.
module plll_front #(
    parameter int MAX_POINTS = plll_pkg::MAX_POINTS_DEF,
    parameter int NUM_CURVES = plll_pkg::NUM_CURVES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  plll_pkg::t_in   i_data,
    output logic            o_q_valid,
    input  logic            i_q_pop,
    output plll_pkg::t_qent o_q
);
    plll_pkg::t_qent r_ent [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    plll_pkg::t_qent v_ent;
    logic            v_keep, v_push;
    logic            v_bad_idx, v_bad_crv;

    always_comb begin
        v_bad_idx = 32'(i_data.index) >= MAX_POINTS;
        v_bad_crv = 32'(i_data.curve) >= NUM_CURVES;
        v_ent.op    = i_data.operation;
        v_ent.curve = i_data.curve;
        v_ent.index = i_data.index;
        v_ent.value = i_data.point_value;
        v_ent.size  = i_data.query_size;
        v_ent.zero  = i_data.query_size == '0;
        v_keep      = 1'b1;
        case (i_data.operation)
            plll_pkg::OP_WR_SIZE: v_ent.bad = v_bad_idx;
            plll_pkg::OP_WR_LAT:  v_ent.bad = v_bad_idx || v_bad_crv;
            plll_pkg::OP_QUERY:   v_ent.bad = v_bad_crv;
            default: begin
                v_ent.bad = 1'b1;
                v_keep    = 1'b0;
            end
        endcase
    end

    assign o_ready   = r_cnt != 2'd2;
    assign o_q_valid = r_cnt != 2'd0;
    assign o_q       = r_ent[r_rp];
    assign v_push    = i_valid && o_ready && v_keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (v_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(v_push) - 2'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_push) begin
            r_ent[r_wp] <= v_ent;
        end
    end
endmodule

// File: sv/plll_back.sv
// Back end: table writes, breakpoint search, multiply, divide and result register.
module plll_back #(
    parameter int MAX_POINTS = plll_pkg::MAX_POINTS_DEF,
    parameter int NUM_CURVES = plll_pkg::NUM_CURVES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  plll_pkg::t_cfg  i_cfg,
    input  logic            i_q_valid,
    output logic            o_q_pop,
    input  plll_pkg::t_qent i_q,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output plll_pkg::t_out  o_out
);
    localparam int PI_W   = $clog2(MAX_POINTS);
    localparam int LDEPTH = NUM_CURVES * MAX_POINTS;
    localparam int LA_W   = $clog2(LDEPTH);
    localparam int VW     = plll_pkg::VAL_W;

    plll_pkg::t_bstate r_state, n_state;
    plll_pkg::t_mode   r_mode, n_mode;
    plll_pkg::t_out    r_out, n_out;
    logic [VW-1:0]     r_size, n_size, r_slast, n_slast, r_sprev, n_sprev;
    logic [VW-1:0]     r_scur, n_scur, r_la, n_la, r_div, n_div;
    logic [VW-1:0]     r_rem, n_rem;
    logic              r_memsl, n_memsl, r_neg, n_neg, r_sat, n_sat;
    logic [PI_W-1:0]   r_nlast, n_nlast, r_si, n_si, r_li, n_li;
    logic [LA_W-1:0]   r_lbase, n_lbase;
    logic [47:0]       r_ma, n_ma, r_mb, n_mb, r_pp, n_pp;
    logic [2:0]        r_k, n_k;
    logic [plll_pkg::PROD_W-1:0] r_acc, n_acc;
    logic [plll_pkg::QUO_W-1:0]  r_quo, n_quo;
    logic [6:0]        r_cnt, n_cnt;

    logic [PI_W-1:0]   v_nlast;
    logic [VW-1:0]     s_rdata, l_rdata;
    logic [PI_W-1:0]   s_raddr;
    logic [LA_W-1:0]   l_raddr;
    logic              s_we, l_we;
    logic signed [VW:0] v_dlat, v_dsize, v_span;
    logic signed [47:0] v_slope;
    logic [2:0]        v_pk;
    logic [6:0]        v_sh;
    logic [95:0]       v_ppw;
    logic [72:0]       v_tq;
    logic [VW:0]       v_rem2;
    logic              v_ge;
    logic [plll_pkg::QUO_W-1:0]  v_qn;
    logic signed [plll_pkg::SUM_W-1:0] v_term, v_sum, v_res;

    always_comb begin
        if (i_cfg.point_count < 6'd3) begin
            v_nlast = PI_W'(2);
        end else if (32'(i_cfg.point_count) > MAX_POINTS) begin
            v_nlast = PI_W'(MAX_POINTS - 1);
        end else begin
            v_nlast = PI_W'(i_cfg.point_count - 6'd1);
        end
    end

    assign o_q_pop = (r_state == plll_pkg::B_IDLE) && i_q_valid;
    assign s_we = o_q_pop && (i_q.op == plll_pkg::OP_WR_SIZE) && !i_q.bad;
    assign l_we = o_q_pop && (i_q.op == plll_pkg::OP_WR_LAT) && !i_q.bad;
    assign s_raddr = (r_state == plll_pkg::B_RD_LAST) ? r_nlast : r_si;
    assign l_raddr = r_lbase + LA_W'(r_li);

    plll_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS)) u_sizes (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(PI_W'(i_q.index)),
        .i_wdata(i_q.value),
        .i_raddr(s_raddr),
        .o_rdata(s_rdata)
    );

    plll_ram #(.WIDTH(VW), .DEPTH(LDEPTH)) u_lats (
        .i_clk  (i_clk),
        .i_we   (l_we),
        .i_waddr(LA_W'(32'(i_q.curve) * MAX_POINTS + 32'(i_q.index))),
        .i_wdata(i_q.value),
        .i_raddr(l_raddr),
        .o_rdata(l_rdata)
    );

    always_comb begin
        n_state = r_state;  n_mode = r_mode;   n_out = r_out;
        n_size = r_size;    n_slast = r_slast; n_sprev = r_sprev;
        n_scur = r_scur;    n_la = r_la;       n_div = r_div;
        n_rem = r_rem;      n_memsl = r_memsl; n_neg = r_neg;
        n_sat = r_sat;      n_nlast = r_nlast; n_si = r_si;
        n_li = r_li;        n_lbase = r_lbase; n_ma = r_ma;
        n_mb = r_mb;        n_pp = r_pp;       n_k = r_k;
        n_acc = r_acc;      n_quo = r_quo;     n_cnt = r_cnt;

        v_dlat  = $signed({1'b0, l_rdata}) - $signed({1'b0, r_la});
        v_dsize = $signed({1'b0, r_size}) - $signed({1'b0, r_sprev});
        v_span  = $signed({1'b0, r_scur}) - $signed({1'b0, r_sprev});
        v_slope = r_memsl ? i_cfg.memory_slope : i_cfg.storage_slope;
        v_pk    = r_k - 3'd1;
        v_sh    = (v_pk[0] ? 7'd24 : 7'd0) + (v_pk[1] ? 7'd24 : 7'd0);
        v_ppw   = {48'b0, r_pp} << v_sh;
        v_tq    = r_acc[plll_pkg::PROD_W-1:16];
        v_rem2  = {r_rem, r_acc[plll_pkg::PROD_W-1]};
        v_ge    = v_rem2 >= {1'b0, r_div};
        v_qn    = {r_quo[plll_pkg::QUO_W-2:0], v_ge};
        v_term  = r_neg ? -$signed({2'b0, r_quo}) : $signed({2'b0, r_quo});
        v_sum   = $signed({13'b0, r_la}) + v_term;
        if (v_sum > plll_pkg::LAT_MAX) begin
            v_res = plll_pkg::LAT_MAX;
        end else if (v_sum < plll_pkg::LAT_MIN) begin
            v_res = plll_pkg::LAT_MIN;
        end else begin
            v_res = v_sum;
        end

        case (r_state)
            plll_pkg::B_IDLE: begin
                if (i_q_valid) begin
                    n_size  = i_q.size;
                    n_lbase = LA_W'(32'(i_q.curve) * MAX_POINTS);
                    n_memsl = i_q.curve < 3'd2;
                    n_nlast = v_nlast;
                    if (i_q.op == plll_pkg::OP_QUERY) begin
                        n_out.latency = '0;
                        if (i_q.zero) begin
                            n_out.status = plll_pkg::ST_ZERO;
                            n_state = plll_pkg::B_OUT;
                        end else if (i_q.bad) begin
                            n_out.status = plll_pkg::ST_NONPOS;
                            n_state = plll_pkg::B_OUT;
                        end else begin
                            n_state = plll_pkg::B_RD_LAST;
                        end
                    end
                end
            end
            plll_pkg::B_RD_LAST: n_state = plll_pkg::B_GOT_LAST;
            plll_pkg::B_GOT_LAST: begin
                n_slast = s_rdata;
                if (r_size == VW'(1)) begin
                    n_mode = plll_pkg::M_ONE;
                    n_li = '0;
                    n_state = plll_pkg::B_RD_LA;
                end else if (r_size > s_rdata) begin
                    n_mode = plll_pkg::M_EXT;
                    n_li = r_nlast;
                    n_state = plll_pkg::B_RD_LA;
                end else begin
                    n_mode = plll_pkg::M_INT;
                    n_si = '0;
                    n_state = plll_pkg::B_RD_S;
                end
            end
            plll_pkg::B_RD_S: n_state = plll_pkg::B_GOT_S;
            plll_pkg::B_GOT_S: begin
                if (r_si == '0) begin
                    n_sprev = s_rdata;
                    n_si = PI_W'(1);
                    n_state = plll_pkg::B_RD_S;
                end else if (s_rdata >= r_size || r_si == r_nlast) begin
                    n_scur = s_rdata;
                    n_li = r_si - PI_W'(1);
                    n_state = plll_pkg::B_RD_LA;
                end else begin
                    n_sprev = s_rdata;
                    n_si = r_si + PI_W'(1);
                    n_state = plll_pkg::B_RD_S;
                end
            end
            plll_pkg::B_RD_LA: n_state = plll_pkg::B_GOT_LA;
            plll_pkg::B_GOT_LA: begin
                n_la = l_rdata;
                case (r_mode)
                    plll_pkg::M_EXT: begin
                        n_ma = v_slope[47] ? 48'(-v_slope) : 48'(v_slope);
                        n_mb = 48'(r_size - r_slast);
                        n_neg = v_slope[47];
                        n_k = '0;
                        n_acc = '0;
                        n_state = plll_pkg::B_MUL;
                    end
                    plll_pkg::M_INT: begin
                        n_li = r_li + PI_W'(1);
                        n_state = plll_pkg::B_RD_LB;
                    end
                    default: begin
                        n_quo = '0;
                        n_neg = 1'b0;
                        n_state = plll_pkg::B_FIN;
                    end
                endcase
            end
            plll_pkg::B_RD_LB: n_state = plll_pkg::B_GOT_LB;
            plll_pkg::B_GOT_LB: begin
                if (v_span == '0) begin
                    n_quo = '0;
                    n_neg = 1'b0;
                    n_state = plll_pkg::B_FIN;
                end else begin
                    n_ma = 48'(v_dlat[VW] ? -v_dlat : v_dlat);
                    n_mb = 48'(v_dsize[VW] ? -v_dsize : v_dsize);
                    n_div = VW'(v_span[VW] ? -v_span : v_span);
                    n_neg = v_dlat[VW] ^ v_dsize[VW] ^ v_span[VW];
                    n_k = '0;
                    n_acc = '0;
                    n_state = plll_pkg::B_MUL;
                end
            end
            plll_pkg::B_MUL: begin
                if (r_k != 3'd0) begin
                    n_acc = r_acc + v_ppw[plll_pkg::PROD_W-1:0];
                end
                if (r_k != 3'd4) begin
                    n_pp = 48'((r_k[0] ? r_ma[47:24] : r_ma[23:0])
                             * (r_k[1] ? r_mb[47:24] : r_mb[23:0]));
                    n_k = r_k + 3'd1;
                end else if (r_mode == plll_pkg::M_EXT) begin
                    n_state = plll_pkg::B_SHIFT;
                end else begin
                    n_rem = '0;
                    n_quo = '0;
                    n_sat = 1'b0;
                    n_cnt = '0;
                    n_state = plll_pkg::B_DIV;
                end
            end
            plll_pkg::B_SHIFT: begin
                n_quo = (v_tq >= 73'(plll_pkg::TERM_CAP)) ? plll_pkg::TERM_CAP
                                                          : plll_pkg::QUO_W'(v_tq);
                n_state = plll_pkg::B_FIN;
            end
            plll_pkg::B_DIV: begin
                n_rem = v_ge ? VW'(v_rem2 - {1'b0, r_div}) : v_rem2[VW-1:0];
                n_acc = r_acc << 1;
                if (!r_sat) begin
                    if (v_qn >= plll_pkg::TERM_CAP) begin
                        n_quo = plll_pkg::TERM_CAP;
                        n_sat = 1'b1;
                    end else begin
                        n_quo = v_qn;
                    end
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'(plll_pkg::PROD_W - 1)) begin
                    n_state = plll_pkg::B_FIN;
                end
            end
            plll_pkg::B_FIN: begin
                n_out.latency = plll_pkg::LAT_W'(v_res);
                n_out.status = (v_res > 0) ? plll_pkg::ST_OK : plll_pkg::ST_NONPOS;
                n_state = plll_pkg::B_OUT;
            end
            plll_pkg::B_OUT: begin
                if (i_out_ready) begin
                    n_state = plll_pkg::B_IDLE;
                end
            end
            default: n_state = plll_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plll_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;   r_out <= n_out;     r_size <= n_size;
        r_slast <= n_slast; r_sprev <= n_sprev; r_scur <= n_scur;
        r_la <= n_la;       r_div <= n_div;     r_rem <= n_rem;
        r_memsl <= n_memsl; r_neg <= n_neg;     r_sat <= n_sat;
        r_nlast <= n_nlast; r_si <= n_si;       r_li <= n_li;
        r_lbase <= n_lbase; r_ma <= n_ma;       r_mb <= n_mb;
        r_pp <= n_pp;       r_k <= n_k;         r_acc <= n_acc;
        r_quo <= n_quo;     r_cnt <= n_cnt;
    end

    assign o_out_valid = r_state == plll_pkg::B_OUT;
    assign o_out       = r_out;

    a_ok_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_out.status == plll_pkg::ST_OK)
            |-> (!r_out.latency[47] && r_out.latency != '0))
        else $error("ok status with a non-positive latency");

    a_zero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_out.status == plll_pkg::ST_ZERO) |-> r_out.latency == '0)
        else $error("zero-size rejection with a nonzero latency");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q.op == plll_pkg::OP_QUERY) |=> r_state != plll_pkg::B_IDLE)
        else $error("query beat popped without starting work");
endmodule

// File: sv/piecewise_linear_latency_lookup.sv
// Top level of the piecewise linear latency lookup: configuration registers and the two halves.
// Writes complete in the back end's idle state; a query with size zero or a bad curve goes
// straight to output. Extrapolated queries go through the table reads and the 4-step multiply.
// Interpolated queries go through the serial search and the one-bit-per-cycle 89-bit divider.
// A two-beat queue decouples input from work. Synchronous active-low reset clears control state
// and sets point_count to 3, slopes to 0.
module piecewise_linear_latency_lookup #(
    parameter int MAX_POINTS = plll_pkg::MAX_POINTS_DEF,
    parameter int NUM_CURVES = plll_pkg::NUM_CURVES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  plll_pkg::t_in              i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output plll_pkg::t_out             o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [plll_pkg::LAT_W-1:0] i_cfg_data
);
    plll_pkg::t_cfg  r_cfg;
    plll_pkg::t_qent w_q;
    logic            w_q_valid, w_q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.point_count   <= 6'd3;
            r_cfg.memory_slope  <= '0;
            r_cfg.storage_slope <= '0;
        end else if (i_cfg_valid) begin
            case (plll_pkg::t_cfg_reg'(i_cfg_index))
                plll_pkg::CFG_POINT_COUNT:   r_cfg.point_count   <= i_cfg_data[5:0];
                plll_pkg::CFG_MEMORY_SLOPE:  r_cfg.memory_slope  <= i_cfg_data;
                plll_pkg::CFG_STORAGE_SLOPE: r_cfg.storage_slope <= i_cfg_data;
                default: ;
            endcase
        end
    end

    plll_front #(.MAX_POINTS(MAX_POINTS), .NUM_CURVES(NUM_CURVES)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_data   (i_in_data),
        .o_q_valid(w_q_valid),
        .i_q_pop  (w_q_pop),
        .o_q      (w_q)
    );

    plll_back #(.MAX_POINTS(MAX_POINTS), .NUM_CURVES(NUM_CURVES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (w_q_valid),
        .o_q_pop    (w_q_pop),
        .i_q        (w_q),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out_data)
    );
endmodule
